@@ hdl/jlsd_pkg.sv @@
// Shared types, register indexes and reset values for the jerk-limited speed to DAC block.
package jlsd_pkg;

  localparam int SpeedWidthDef = 32;
  localparam int DacWidthDef   = 16;

  localparam int CfgIdxWidth  = 4;
  localparam int CfgDataWidth = 32;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SPEED_LIMIT   = 4'd0,
    CFG_MAX_ACCEL     = 4'd1,
    CFG_JERK_LIMIT    = 4'd2,
    CFG_UNIT_GAIN     = 4'd3,
    CFG_ZERO_OFFSET   = 4'd4,
    CFG_ZERO_DAC_CODE = 4'd5,
    CFG_MAX_DRIVE     = 4'd6,
    CFG_ZERO_BAND     = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [30:0] speed_limit;
    logic [30:0] max_accel;
    logic [30:0] jerk_limit;
    logic [31:0] unit_gain;
    logic [15:0] zero_offset;
    logic [15:0] zero_dac_code;
    logic [14:0] max_drive;
    logic [30:0] zero_band;
  } cfg_t;

  localparam logic [30:0] SpeedLimitRst  = 31'h7FFF_FFFF;
  localparam logic [30:0] MaxAccelRst    = 31'd65536;
  localparam logic [30:0] JerkLimitRst   = 31'd6554;
  localparam logic [31:0] UnitGainRst    = 32'd65536;
  localparam logic [15:0] ZeroOffsetRst  = 16'd0;
  localparam logic [15:0] ZeroDacCodeRst = 16'd32768;
  localparam logic [14:0] MaxDriveRst    = 15'd32767;
  localparam logic [30:0] ZeroBandRst    = 31'd655;

endpackage

@@ hdl/jlsd_cfg_regs.sv @@
// Configuration register file of the jerk-limited speed to DAC block.
module jlsd_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [jlsd_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [jlsd_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output jlsd_pkg::cfg_t                      cfg_o
);

  jlsd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (jlsd_pkg::cfg_idx_e'(cfg_index_i))
        jlsd_pkg::CFG_SPEED_LIMIT:   cfg_d.speed_limit   = cfg_data_i[30:0];
        jlsd_pkg::CFG_MAX_ACCEL:     cfg_d.max_accel     = cfg_data_i[30:0];
        jlsd_pkg::CFG_JERK_LIMIT:    cfg_d.jerk_limit    = cfg_data_i[30:0];
        jlsd_pkg::CFG_UNIT_GAIN:     cfg_d.unit_gain     = cfg_data_i[31:0];
        jlsd_pkg::CFG_ZERO_OFFSET:   cfg_d.zero_offset   = cfg_data_i[15:0];
        jlsd_pkg::CFG_ZERO_DAC_CODE: cfg_d.zero_dac_code = cfg_data_i[15:0];
        jlsd_pkg::CFG_MAX_DRIVE:     cfg_d.max_drive     = cfg_data_i[14:0];
        jlsd_pkg::CFG_ZERO_BAND:     cfg_d.zero_band     = cfg_data_i[30:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_limit   <= jlsd_pkg::SpeedLimitRst;
      cfg_q.max_accel     <= jlsd_pkg::MaxAccelRst;
      cfg_q.jerk_limit    <= jlsd_pkg::JerkLimitRst;
      cfg_q.unit_gain     <= jlsd_pkg::UnitGainRst;
      cfg_q.zero_offset   <= jlsd_pkg::ZeroOffsetRst;
      cfg_q.zero_dac_code <= jlsd_pkg::ZeroDacCodeRst;
      cfg_q.max_drive     <= jlsd_pkg::MaxDriveRst;
      cfg_q.zero_band     <= jlsd_pkg::ZeroBandRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/jlsd_ramp.sv @@
// Speed clamp and jerk-limited step limiter with its speed and acceleration state.
module jlsd_ramp #(
  parameter int SPEED_WIDTH = jlsd_pkg::SpeedWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jlsd_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SPEED_WIDTH-1:0] target_speed_i,
  output logic                          spd_valid_o,
  input  logic                          spd_ready_i,
  output logic signed [SPEED_WIDTH-1:0] speed_o
);

  localparam int CW = ((SPEED_WIDTH > 32) ? SPEED_WIDTH : 32) + 3;
  localparam logic signed [CW-1:0] SMax = {{(CW-SPEED_WIDTH+1){1'b0}}, {(SPEED_WIDTH-1){1'b1}}};
  localparam logic signed [CW-1:0] SMin = ~SMax;

  logic                          s1_valid_q;
  logic signed [SPEED_WIDTH-1:0] s1_target_q;
  logic                          s2_valid_q;
  logic signed [SPEED_WIDTH-1:0] s2_speed_q;
  logic signed [SPEED_WIDTH-1:0] prev_speed_q, prev_speed_d;
  logic signed [SPEED_WIDTH-1:0] prev_accel_q, prev_accel_d;

  logic s1_ready, s2_ready, s1_fire;

  logic signed [CW-1:0] t_x, ms, ma, mj, ps, pa, tc, up, dn, hi_b, lo_b, sp, sp_sat, acc, acc_sat;

  assign s2_ready   = !s2_valid_q || spd_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s1_fire    = s1_valid_q && s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    t_x = CW'(s1_target_q);
    ms  = CW'({1'b0, cfg_i.speed_limit});
    ma  = CW'({1'b0, cfg_i.max_accel});
    mj  = CW'({1'b0, cfg_i.jerk_limit});
    ps  = CW'(prev_speed_q);
    pa  = CW'(prev_accel_q);

    tc = t_x;
    if (tc > ms)  tc = ms;
    if (tc < -ms) tc = -ms;

    up = pa + mj;
    if (up > ma) up = ma;
    dn = pa - mj;
    if (dn < -ma) dn = -ma;

    // The lower bound is applied last so it wins when the bounds cross.
    hi_b = ps + up;
    lo_b = ps + dn;
    sp   = tc;
    if (sp > hi_b) sp = hi_b;
    if (sp < lo_b) sp = lo_b;

    sp_sat = sp;
    if (sp_sat > SMax) sp_sat = SMax;
    if (sp_sat < SMin) sp_sat = SMin;

    acc     = sp_sat - ps;
    acc_sat = acc;
    if (acc_sat > SMax) acc_sat = SMax;
    if (acc_sat < SMin) acc_sat = SMin;

    prev_speed_d = sp_sat[SPEED_WIDTH-1:0];
    prev_accel_d = acc_sat[SPEED_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      prev_speed_q <= '0;
      prev_accel_q <= '0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s1_fire) begin
        prev_speed_q <= prev_speed_d;
        prev_accel_q <= prev_accel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) s1_target_q <= target_speed_i;
    if (s1_fire)                s2_speed_q  <= prev_speed_d;
  end

  assign spd_valid_o = s2_valid_q;
  assign speed_o     = s2_speed_q;

endmodule

@@ hdl/jlsd_dac_map.sv @@
// Speed to DAC code mapping: gain multiply, offset, drive saturation and dead band.
module jlsd_dac_map #(
  parameter int SPEED_WIDTH = jlsd_pkg::SpeedWidthDef,
  parameter int DAC_WIDTH   = jlsd_pkg::DacWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jlsd_pkg::cfg_t                cfg_i,
  input  logic                          spd_valid_i,
  output logic                          spd_ready_o,
  input  logic signed [SPEED_WIDTH-1:0] speed_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [DAC_WIDTH-1:0]          dac_code_o,
  output logic signed [SPEED_WIDTH-1:0] limited_speed_o,
  output logic                          zero_clamp_o
);

  localparam int AW  = (SPEED_WIDTH > 17) ? SPEED_WIDTH : 17;
  localparam int HPW = AW - 16 + 32;
  localparam int ZW  = ((SPEED_WIDTH > 32) ? SPEED_WIDTH : 32) + 2;
  localparam int KW  = ((DAC_WIDTH > 17) ? DAC_WIDTH : 17) + 2;
  localparam logic signed [KW-1:0] DMax = {{(KW-DAC_WIDTH){1'b0}}, {DAC_WIDTH{1'b1}}};

  // Stage 3: partial products and sign/band flags.
  logic                          s3_valid_q;
  logic [HPW-1:0]                s3_hi_q;
  logic [47:0]                   s3_lo_q;
  logic                          s3_sgn_q, s3_pos_q, s3_neg_q;
  logic signed [SPEED_WIDTH-1:0] s3_speed_q;
  // Stage 4: saturated drive magnitude.
  logic                          s4_valid_q;
  logic [14:0]                   s4_drive_q;
  logic                          s4_pos_q, s4_neg_q;
  logic signed [SPEED_WIDTH-1:0] s4_speed_q;
  // Output register.
  logic                          out_valid_q;
  logic [DAC_WIDTH-1:0]          out_code_q;
  logic signed [SPEED_WIDTH-1:0] out_speed_q;
  logic                          out_clamp_q;

  logic s3_ready, s4_ready, out_ready;

  logic signed [AW:0]   sx, ax;
  logic [AW-1:0]        mag_a;
  logic [HPW-1:0]       hi_d;
  logic [47:0]          lo_d;
  logic signed [ZW-1:0] sz, zb;
  logic                 pos_d, neg_d;

  logic [63:0]          hi64, p;
  logic                 huge;
  logic signed [65:0]   pe, sd, off66, d, dabs;
  logic [33:0]          mag34;
  logic [14:0]          drive_d;

  logic signed [KW-1:0] zd_k, dr_k, off_k, code_k;
  logic [DAC_WIDTH-1:0] code_d;

  assign out_ready   = !out_valid_q || out_ready_i;
  assign s4_ready    = !s4_valid_q || out_ready;
  assign s3_ready    = !s3_valid_q || s4_ready;
  assign spd_ready_o = s3_ready;

  always_comb begin
    sx    = (AW+1)'(speed_i);
    ax    = sx[AW] ? -sx : sx;
    mag_a = ax[AW-1:0];
    hi_d  = HPW'(mag_a[AW-1:16]) * HPW'(cfg_i.unit_gain);
    lo_d  = 48'(mag_a[15:0]) * 48'(cfg_i.unit_gain);
    sz    = ZW'(speed_i);
    zb    = ZW'({1'b0, cfg_i.zero_band});
    pos_d = sz > zb;
    neg_d = sz < -zb;
  end

  always_comb begin
    hi64  = 64'(s3_hi_q);
    huge  = hi64 >= (64'd1 << 46);
    p     = (hi64 << 16) + 64'(s3_lo_q);
    pe    = $signed({2'b00, p});
    sd    = s3_sgn_q ? -pe : pe;
    off66 = $signed({{18{cfg_i.zero_offset[15]}}, cfg_i.zero_offset, 32'd0});
    d     = sd - off66;
    dabs  = d[65] ? -d : d;
    mag34 = dabs[65:32];
    if (huge || (mag34 > 34'(cfg_i.max_drive))) begin
      drive_d = cfg_i.max_drive;
    end else begin
      drive_d = mag34[14:0];
    end
  end

  always_comb begin
    zd_k  = KW'({1'b0, cfg_i.zero_dac_code});
    dr_k  = KW'({1'b0, s4_drive_q});
    off_k = KW'($signed(cfg_i.zero_offset));
    if (s4_pos_q) begin
      code_k = zd_k + dr_k;
    end else if (s4_neg_q) begin
      code_k = zd_k - dr_k;
    end else begin
      code_k = zd_k - off_k;
    end
    if (code_k < 0)    code_k = '0;
    if (code_k > DMax) code_k = DMax;
    code_d = code_k[DAC_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s3_ready)  s3_valid_q  <= spd_valid_i;
      if (s4_ready)  s4_valid_q  <= s3_valid_q;
      if (out_ready) out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && spd_valid_i) begin
      s3_hi_q    <= hi_d;
      s3_lo_q    <= lo_d;
      s3_sgn_q   <= sx[AW];
      s3_pos_q   <= pos_d;
      s3_neg_q   <= neg_d;
      s3_speed_q <= speed_i;
    end
    if (s4_ready && s3_valid_q) begin
      s4_drive_q <= drive_d;
      s4_pos_q   <= s3_pos_q;
      s4_neg_q   <= s3_neg_q;
      s4_speed_q <= s3_speed_q;
    end
    if (out_ready && s4_valid_q) begin
      out_code_q  <= code_d;
      out_speed_q <= s4_speed_q;
      out_clamp_q <= !(s4_pos_q || s4_neg_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign dac_code_o      = out_code_q;
  assign limited_speed_o = out_speed_q;
  assign zero_clamp_o    = out_clamp_q;

endmodule

@@ hdl/jerk_limited_speed_to_dac.sv @@
// Top level of the jerk-limited speed ramp driving a servo speed DAC.
// Pipeline: a request passes through the input register, limiter, multiplier, drive
// and code stages in that order before its result shows on the output.
// Throughput: one request per cycle unless the output stalls; the speed and
// acceleration state updates in the single limiter stage, so each request sees the
// state left by the one before. Reset (rst_ni low, asynchronous) empties the pipeline,
// clears speed and acceleration to zero and loads every configuration register with its default.
module jerk_limited_speed_to_dac #(
  parameter int SPEED_WIDTH = jlsd_pkg::SpeedWidthDef,
  parameter int DAC_WIDTH   = jlsd_pkg::DacWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [jlsd_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [jlsd_pkg::CfgDataWidth-1:0]   cfg_data_i,
  // Target speed requests.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SPEED_WIDTH-1:0]       target_speed_i,
  // Result requests.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [DAC_WIDTH-1:0]                dac_code_o,
  output logic signed [SPEED_WIDTH-1:0]       limited_speed_o,
  output logic                                zero_clamp_o
);

  localparam int ZW = ((SPEED_WIDTH > 32) ? SPEED_WIDTH : 32) + 2;

  jlsd_pkg::cfg_t cfg;

  logic                          spd_valid;
  logic                          spd_ready;
  logic signed [SPEED_WIDTH-1:0] speed;

  // Registers are always writable, so the host must write them only while the block is idle.
  assign cfg_ready_o = 1'b1;

  jlsd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Clamp to max speed, then bound the step by the acceleration and jerk limits.
  jlsd_ramp #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_ramp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .target_speed_i (target_speed_i),
    .spd_valid_o    (spd_valid),
    .spd_ready_i    (spd_ready),
    .speed_o        (speed)
  );

  // Scale by the gain, remove the zero offset and map onto the DAC code range.
  jlsd_dac_map #(
    .SPEED_WIDTH (SPEED_WIDTH),
    .DAC_WIDTH   (DAC_WIDTH)
  ) u_dac_map (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .spd_valid_i     (spd_valid),
    .spd_ready_o     (spd_ready),
    .speed_i         (speed),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dac_code_o      (dac_code_o),
    .limited_speed_o (limited_speed_o),
    .zero_clamp_o    (zero_clamp_o)
  );

  // Speed and band width in a common signed width for the checks below.
  logic signed [ZW-1:0] lim_z, band_z;
  assign lim_z  = ZW'(limited_speed_o);
  assign band_z = ZW'({1'b0, cfg.zero_band});

  // The input side only stalls when every stage is full behind a waiting result.
  a_ready_only_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the output was not backed up");

  // A zero clamp result carries a speed inside the dead band.
  a_clamp_in_band : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_clamp_o) |-> ((lim_z <= band_z) && (lim_z >= -band_z)))
    else $error("zero clamp asserted outside the dead band");

  // Outside the band no clamp is requested.
  a_no_clamp_out_band : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((lim_z > band_z) || (lim_z < -band_z))) |-> !zero_clamp_o)
    else $error("zero clamp missing for a speed outside the dead band");

endmodule

@@ tb/sv/jlsd_ramp_checker.sv @@
// Checker that predicts the jerk-limited ramp and DAC code results and compares them.
`timescale 1ns / 1ps
module jlsd_ramp_checker (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_valid_i,
  input  logic                                      cfg_ready_i,
  input  logic [jlsd_pkg::CfgIdxWidth-1:0]          cfg_index_i,
  input  logic [jlsd_pkg::CfgDataWidth-1:0]         cfg_data_i,
  input  logic                                      in_valid_i,
  input  logic                                      in_ready_i,
  input  logic signed [jlsd_pkg::SpeedWidthDef-1:0] target_speed_i,
  input  logic                                      out_valid_i,
  input  logic                                      out_ready_i,
  input  logic [jlsd_pkg::DacWidthDef-1:0]          dac_code_i,
  input  logic signed [jlsd_pkg::SpeedWidthDef-1:0] limited_speed_i,
  input  logic                                      zero_clamp_i,
  output int                                        err_count_o,
  output int                                        pending_o,
  output int                                        checked_o,
  output int                                        clamp_count_o
);

  localparam longint SpeedMax    = (longint'(1) <<< (jlsd_pkg::SpeedWidthDef - 1)) - 1;
  localparam longint SpeedMin    = -SpeedMax - 1;
  localparam longint DacMax      = (longint'(1) <<< jlsd_pkg::DacWidthDef) - 1;
  localparam int     ReportLimit = 10;

  typedef struct {
    logic [jlsd_pkg::DacWidthDef-1:0]          dac;
    logic signed [jlsd_pkg::SpeedWidthDef-1:0] speed;
    logic                                      clamp;
  } servo_cmd_t;

  servo_cmd_t     servo_cmd_q[$];
  servo_cmd_t     want;
  jlsd_pkg::cfg_t regs_q;
  longint         speed_q;
  longint         accel_q;
  int             err_count;
  int             checked;
  int             clamp_count;

  assign err_count_o   = err_count;
  assign pending_o     = servo_cmd_q.size();
  assign checked_o     = checked;
  assign clamp_count_o = clamp_count;

  // Magnitude of trunc(speed * gain - offset) in DAC codes, saturated to max_drive.
  function automatic longint dac_drive_mag(input longint spd);
    logic [63:0] mag_in;
    logic [63:0] hi_prod;
    logic [63:0] prod;
    logic [63:0] mag;
    longint      diff;
    mag_in  = (spd < 0) ? 64'(-spd) : 64'(spd);
    hi_prod = (mag_in >> 16) * 64'(regs_q.unit_gain);
    if (hi_prod >= (64'd1 << 46)) return longint'(regs_q.max_drive);
    prod = (hi_prod << 16) + (mag_in & 64'hFFFF) * 64'(regs_q.unit_gain);
    diff = ((spd < 0) ? -longint'(prod) : longint'(prod))
         - longint'($signed(regs_q.zero_offset)) * (longint'(1) <<< 32);
    mag  = ((diff < 0) ? 64'(-diff) : 64'(diff)) >> 32;
    if (mag > 64'(regs_q.max_drive)) return longint'(regs_q.max_drive);
    return longint'(mag);
  endfunction

  // One control tick: clamp, jerk and acceleration limits, state update, DAC code.
  function automatic servo_cmd_t advance_ramp(
      input logic signed [jlsd_pkg::SpeedWidthDef-1:0] target);
    longint     tgt;
    longint     lim;
    longint     step_up;
    longint     step_dn;
    longint     spd;
    longint     acc;
    longint     mag;
    longint     band;
    longint     code;
    servo_cmd_t cmd;
    lim  = longint'(regs_q.speed_limit);
    band = longint'(regs_q.zero_band);
    tgt  = longint'(target);
    if (tgt > lim) tgt = lim;
    if (tgt < -lim) tgt = -lim;
    step_up = accel_q + longint'(regs_q.jerk_limit);
    if (step_up > longint'(regs_q.max_accel)) step_up = longint'(regs_q.max_accel);
    step_dn = accel_q - longint'(regs_q.jerk_limit);
    if (step_dn < -longint'(regs_q.max_accel)) step_dn = -longint'(regs_q.max_accel);
    // The lower bound is applied last so that it wins when the bounds cross.
    spd = tgt;
    if (spd > speed_q + step_up) spd = speed_q + step_up;
    if (spd < speed_q + step_dn) spd = speed_q + step_dn;
    if (spd > SpeedMax) spd = SpeedMax;
    if (spd < SpeedMin) spd = SpeedMin;
    acc = spd - speed_q;
    if (acc > SpeedMax) acc = SpeedMax;
    if (acc < SpeedMin) acc = SpeedMin;
    speed_q = spd;
    accel_q = acc;
    mag       = dac_drive_mag(spd);
    cmd.clamp = 1'b0;
    if (spd > band) begin
      code = longint'(regs_q.zero_dac_code) + mag;
    end else if (spd < -band) begin
      code = longint'(regs_q.zero_dac_code) - mag;
    end else begin
      code      = longint'(regs_q.zero_dac_code) - longint'($signed(regs_q.zero_offset));
      cmd.clamp = 1'b1;
    end
    if (code > DacMax) code = DacMax;
    if (code < 0) code = 0;
    cmd.dac   = code[jlsd_pkg::DacWidthDef-1:0];
    cmd.speed = spd[jlsd_pkg::SpeedWidthDef-1:0];
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.speed_limit   = jlsd_pkg::SpeedLimitRst;
      regs_q.max_accel     = jlsd_pkg::MaxAccelRst;
      regs_q.jerk_limit    = jlsd_pkg::JerkLimitRst;
      regs_q.unit_gain     = jlsd_pkg::UnitGainRst;
      regs_q.zero_offset   = jlsd_pkg::ZeroOffsetRst;
      regs_q.zero_dac_code = jlsd_pkg::ZeroDacCodeRst;
      regs_q.max_drive     = jlsd_pkg::MaxDriveRst;
      regs_q.zero_band     = jlsd_pkg::ZeroBandRst;
      speed_q     = 0;
      accel_q     = 0;
      err_count   = 0;
      checked     = 0;
      clamp_count = 0;
      servo_cmd_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (jlsd_pkg::cfg_idx_e'(cfg_index_i))
          jlsd_pkg::CFG_SPEED_LIMIT:   regs_q.speed_limit   = cfg_data_i[30:0];
          jlsd_pkg::CFG_MAX_ACCEL:     regs_q.max_accel     = cfg_data_i[30:0];
          jlsd_pkg::CFG_JERK_LIMIT:    regs_q.jerk_limit    = cfg_data_i[30:0];
          jlsd_pkg::CFG_UNIT_GAIN:     regs_q.unit_gain     = cfg_data_i[31:0];
          jlsd_pkg::CFG_ZERO_OFFSET:   regs_q.zero_offset   = cfg_data_i[15:0];
          jlsd_pkg::CFG_ZERO_DAC_CODE: regs_q.zero_dac_code = cfg_data_i[15:0];
          jlsd_pkg::CFG_MAX_DRIVE:     regs_q.max_drive     = cfg_data_i[14:0];
          jlsd_pkg::CFG_ZERO_BAND:     regs_q.zero_band     = cfg_data_i[30:0];
          default: ;
        endcase
      end
      // Results are matched before new requests are queued, so a result can never
      // be paired with a request accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (servo_cmd_q.size() == 0) begin
          err_count++;
          if (err_count <= ReportLimit) begin
            $display("%t: result with nothing expected: dac %0d speed %0d clamp %0b",
                     $time, dac_code_i, limited_speed_i, zero_clamp_i);
          end
        end else begin
          want = servo_cmd_q.pop_front();
          checked++;
          if (want.clamp) clamp_count++;
          if (want.dac !== dac_code_i || want.speed !== limited_speed_i ||
              want.clamp !== zero_clamp_i) begin
            err_count++;
            if (err_count <= ReportLimit) begin
              $display("%t: mismatch: expected dac %0d speed %0d clamp %0b, got dac %0d speed %0d clamp %0b",
                       $time, want.dac, want.speed, want.clamp,
                       dac_code_i, limited_speed_i, zero_clamp_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        servo_cmd_q.push_back(advance_ramp(target_speed_i));
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Top level testbench: stimulus, handshake idling and verdict for the speed to DAC block.
`timescale 1ns / 1ps
module tb_top;

  // Clock and reset timing.
  localparam int ClkHalfNs   = 5;
  localparam int ResetCycles = 7;
  // Idle wait used to let the block settle after the last result.
  localparam int PipeLatency = 4;
  // Longest per-request wait that either side draws.
  localparam int MaxIdle     = 6;
  // Length of the long receiver hold-off that fills up the pipeline.
  localparam int HoldCycles  = 300;
  // Random part: phases, each with its own register setting and idling mix.
  localparam int PhaseCount    = 12;
  localparam int ItemsPerPhase = 150;
  // Watchdog timeout in ns, with ample margin over the slowest correct run.
  localparam int TimeoutNs     = 5_000_000;

  localparam logic [31:0] SpeedTop    = 32'h7FFF_FFFF;
  localparam logic [31:0] SpeedBottom = 32'h8000_0000;

  logic                                      clk;
  logic                                      rst_n;
  logic                                      cfg_valid;
  logic                                      cfg_ready;
  logic [jlsd_pkg::CfgIdxWidth-1:0]          cfg_index;
  logic [jlsd_pkg::CfgDataWidth-1:0]         cfg_data;
  logic                                      in_valid;
  logic                                      in_ready;
  logic signed [jlsd_pkg::SpeedWidthDef-1:0] target;
  logic                                      out_valid;
  logic                                      out_ready;
  logic [jlsd_pkg::DacWidthDef-1:0]          dac_code;
  logic signed [jlsd_pkg::SpeedWidthDef-1:0] limited_speed;
  logic                                      zero_clamp;

  int err_count;
  int pending;
  int checked;
  int clamp_count;

  // Knobs shared between the stimulus process and the result sink.
  int   gap_max;
  int   stall_max;
  logic hold_req;
  int   holds_done;
  int   requests_sent;
  int   settings_done;
  // Last dead band written, so targets can be aimed at its edges.
  logic [30:0] band_now;

  always begin
    clk = 1'b0;
    #(ClkHalfNs);
    clk = 1'b1;
    #(ClkHalfNs);
  end

  jerk_limited_speed_to_dac u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .target_speed_i (target),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .dac_code_o     (dac_code),
    .limited_speed_o(limited_speed),
    .zero_clamp_o   (zero_clamp)
  );

  jlsd_ramp_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .target_speed_i (target),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .dac_code_i     (dac_code),
    .limited_speed_i(limited_speed),
    .zero_clamp_i   (zero_clamp),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .clamp_count_o  (clamp_count)
  );

  // Offers one target speed request. The task starts and ends at a falling edge, and
  // valid is only lowered when a gap is drawn, so back-to-back requests keep it high.
  task automatic send_target(input logic [31:0] speed);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    target   <= speed;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    requests_sent++;
  endtask

  // Stops offering requests until every expected result is back, then lets the
  // pipeline settle so that the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PipeLatency) @(negedge clk);
  endtask

  // One register write. Valid is left high; the caller lowers it after the last write.
  task automatic write_reg(input logic [jlsd_pkg::CfgIdxWidth-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Writes a complete register setting once the block is idle. Every setting also
  // carries one write to an index past the last register, which must be ignored.
  task automatic program_regs(input logic [31:0] speed_limit, input logic [31:0] max_accel,
                              input logic [31:0] jerk_limit, input logic [31:0] unit_gain,
                              input logic [31:0] zero_offset, input logic [31:0] zero_code,
                              input logic [31:0] max_drive, input logic [31:0] zero_band);
    drain();
    write_reg(jlsd_pkg::CFG_SPEED_LIMIT, speed_limit);
    write_reg(jlsd_pkg::CFG_MAX_ACCEL, max_accel);
    write_reg(jlsd_pkg::CFG_JERK_LIMIT, jerk_limit);
    write_reg(jlsd_pkg::CFG_UNIT_GAIN, unit_gain);
    write_reg(jlsd_pkg::CFG_ZERO_OFFSET, zero_offset);
    write_reg(jlsd_pkg::CFG_ZERO_DAC_CODE, zero_code);
    write_reg(jlsd_pkg::CFG_MAX_DRIVE, max_drive);
    write_reg(jlsd_pkg::CFG_ZERO_BAND, zero_band);
    write_reg(jlsd_pkg::CfgIdxWidth'(jlsd_pkg::CFG_ZERO_BAND)
              + jlsd_pkg::CfgIdxWidth'($urandom_range(1, 8)), $urandom());
    cfg_valid <= 1'b0;
    band_now = zero_band[30:0];
    settings_done++;
  endtask

  // A field value of the given width, often at an extreme, with random junk above
  // the field so that the block's masking of unused data bits is exercised.
  function automatic logic [31:0] rand_field(input int width);
    logic [31:0] mask;
    logic [31:0] val;
    mask = 32'hFFFF_FFFF >> (32 - width);
    case ($urandom_range(0, 3))
      0:       val = '0;
      1:       val = mask;
      2:       val = $urandom();
      default: val = $urandom() >> $urandom_range(0, 31);
    endcase
    return ($urandom() & ~mask) | (val & mask);
  endfunction

  // Three flavors of setting: anything at all, a plausible servo tuning, and a
  // loose one where the speed follows the target quickly.
  task automatic random_setting(input int flavor);
    logic [31:0] accel;
    case (flavor)
      0: begin
        program_regs(rand_field(31), rand_field(31), rand_field(31), rand_field(32),
                     rand_field(16), rand_field(16), rand_field(15), rand_field(31));
      end
      1: begin
        accel = $urandom_range(1 << 8, 1 << 20);
        program_regs($urandom_range(1 << 16, 1 << 26), accel, $urandom_range(0, accel),
                     $urandom_range(1 << 10, 1 << 24),
                     32'($urandom_range(0, 1024)) - 32'd512,
                     $urandom_range(16384, 49152), $urandom_range(0, 32767),
                     $urandom_range(0, 1 << 14));
      end
      default: begin
        program_regs(rand_field(31), SpeedTop >> $urandom_range(0, 8),
                     SpeedTop >> $urandom_range(0, 8), $urandom() >> $urandom_range(0, 16),
                     rand_field(16), rand_field(16), rand_field(15),
                     $urandom() >> $urandom_range(8, 31));
      end
    endcase
  endtask

  // Target speeds: extremes, the dead band edges, raw random words and random
  // values spread over the magnitudes by an arithmetic shift, which flavor 1 keeps smaller.
  function automatic logic [31:0] pick_target(input int flavor);
    logic [31:0] edge_val;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SpeedTop;
      2: return SpeedBottom;
      3: begin
        edge_val = {1'b0, band_now} + 32'($urandom_range(0, 2)) - 32'd1;
        return $urandom_range(0, 1) ? edge_val : -edge_val;
      end
      4, 5: return $urandom();
      default: return 32'($signed($urandom()) >>> $urandom_range(flavor == 1 ? 6 : 0, 31));
    endcase
  endfunction

  // Result sink. For every result it draws a stall, then holds ready high until the
  // result is taken. When asked, it first holds ready low for a long stretch so the
  // pipeline fills and the block has to push back on new requests.
  initial begin : result_sink
    int stall;
    out_ready  = 1'b0;
    holds_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      stall = $urandom_range(0, stall_max);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stimulus
    int failures;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    target        = '0;
    gap_max       = 0;
    stall_max     = 0;
    hold_req      = 1'b0;
    requests_sent = 0;
    settings_done = 0;
    band_now      = jlsd_pkg::ZeroBandRst;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. At the reset setting the ramp is slow: check the dead band
    // edge at both signs and the two extreme targets.
    send_target('0);
    send_target(32'd655);
    send_target(32'd656);
    send_target(-32'sd655);
    send_target(-32'sd656);
    send_target(SpeedTop);
    send_target(SpeedBottom);
    send_target(32'hFFFF_FFFF);

    // No limits, largest gain and most negative offset: huge products and codes
    // that overflow the top of the DAC range, in and out of the dead band.
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h0000_8000, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_target(SpeedTop);
    send_target(SpeedBottom);
    send_target(32'd1);
    send_target('0);

    // Dead band covering everything with the largest positive offset: the code
    // falls below zero and must saturate at the bottom.
    program_regs(SpeedTop, SpeedTop, SpeedTop, 32'd65536,
                 32'h0000_7FFF, 32'h0, 32'h7FFF, SpeedTop);
    send_target(SpeedBottom);

    // Small zero code and a drive limit: a negative speed saturates the code at the
    // bottom outside the dead band. Then build up a large acceleration.
    program_regs(SpeedTop, SpeedTop, SpeedTop, 32'd65536,
                 32'h0, 32'd50, 32'd100, 32'h0);
    send_target(-32'sd13107200);
    send_target('0);
    send_target(32'h4000_0000);

    // With no jerk allowed the step keeps its last value, so the speed runs past
    // the top of its range and has to saturate.
    program_regs(SpeedTop, SpeedTop, 32'h0, 32'd65536,
                 32'h0, 32'd32768, 32'h7FFF, 32'd655);
    send_target(SpeedTop);

    // A tiny acceleration limit below the stored step crosses the step bounds;
    // the lower bound must win. The next request sees a clean state again.
    program_regs(SpeedTop, 32'd16, 32'h0, 32'd65536,
                 32'h0, 32'd32768, 32'h7FFF, 32'd655);
    send_target('0);
    send_target('0);

    // A zero speed limit pins every target to zero.
    program_regs(32'h0, SpeedTop, SpeedTop, 32'd65536,
                 32'h0, 32'd32768, 32'h0, 32'd655);
    send_target(SpeedTop);
    send_target(SpeedBottom);

    // Random part. Idling cycles through none, sender only, both and receiver only.
    for (int p = 0; p < PhaseCount; p++) begin
      gap_max   = (p % 4 == 1 || p % 4 == 2) ? MaxIdle : 0;
      stall_max = (p % 4 >= 2) ? MaxIdle : 0;
      random_setting(p % 3);
      if (p == 4) begin
        // Keep requests coming back to back while the receiver holds off.
        gap_max  = 0;
        hold_req = 1'b1;
      end
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p % 2 == 1 && n == ItemsPerPhase / 2) drain();
        send_target(pick_target(p % 3));
      end
    end

    drain();
    repeat (PipeLatency * 4) @(negedge clk);
    failures = err_count + pending;
    $display("Sent %0d target speed requests over %0d register settings, %0d long hold-off(s).",
             requests_sent, settings_done, holds_done);
    $display("Checked %0d results, %0d in the dead band; %0d failure(s).",
             checked, clamp_count, failures);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Timeout after %0d ns with %0d result(s) still expected.", TimeoutNs, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
